@@ sv/buzzer_tone_click_sequencer_defines.svh @@
// Assertion macros used by the buzzer sequencer top file.
// Each macro expands to one labelled concurrent assertion on the rising clock edge,
// switched off while reset is asserted.
`ifndef BUZZER_TONE_CLICK_SEQUENCER_DEFINES_SVH
`define BUZZER_TONE_CLICK_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define BTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("buzzer sequencer: same-cycle check failed");

// Next-cycle implication.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("buzzer sequencer: next-cycle check failed");

`endif

@@ sv/bts_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_pkg
// Types and constants shared by the buzzer tone and click sequencer modules.
// ---------------------------------------------------------------------------
package bts_pkg;

	localparam int CNT_W  = 16;
	localparam int LONG_W = 26;
	localparam int HZ_W   = 19;
	localparam int CLK_W  = 8;
	localparam int MODE_W = 2;
	localparam int STEP_W = 5;

	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLICK = 2'd2;

	localparam logic [CNT_W-1:0] TOP_RESET = 16'd1000;
	localparam logic [CNT_W-1:0] TOP_MAX   = 16'hFFFF;

	typedef struct packed {
		logic              kind;
		logic [HZ_W-1:0]   tone_hz;
		logic [MODE_W-1:0] play_mode;
		logic [CNT_W-1:0]  duration;
		logic [CLK_W-1:0]  click_count;
	} cmd_t;

	typedef struct packed {
		logic pwm_out;
		logic busy_res;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic tick;
		logic div_hz;
		logic div_click;
		logic load;
		logic res_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic kind;
		logic div_done;
	} dp_sts_t;

endpackage

@@ sv/buzzer_tone_click_sequencer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buzzer_tone_click_sequencer
// PWM buzzer tone generator with timed duration and clicking mode.
// ---------------------------------------------------------------------------
// Usage:
// The cmd channel takes one word per item: a timer tick (kind 0) or a start
// command (kind 1) carrying tone, mode, duration and click count. Every item
// gives exactly one word on the res channel: the PWM level and busy flag as
// they stand after the item.
// A tick word is applied in the cycle after acceptance; the result word is
// then registered in the response state, and the next word can be taken once
// the block is back in idle.
// A start word runs the single shared divider twice, 26 quotient bits at one
// bit per cycle, once for the period top and once for the click interval;
// the new tone is loaded after the second division, then the result word is
// registered, and only then can the next word be taken.
// Reset clears the tone (not running, period top 1000) and empties the
// result register. While the receiver stalls, the result word is held in the
// output register; the block still takes one further word and processes it,
// then holds cmd_stall high until the waiting result has been taken.
// ---------------------------------------------------------------------------
`include "buzzer_tone_click_sequencer_defines.svh"

module buzzer_tone_click_sequencer #(
	parameter int PERIODS_PER_UNIT = 300,
	parameter int TICK_HZ          = 800000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  bts_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output bts_pkg::res_t res
);

	bts_pkg::dp_cmd_t ctl;
	bts_pkg::dp_sts_t sts;

	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	bts_dp #(
		.PERIODS_PER_UNIT (PERIODS_PER_UNIT),
		.TICK_HZ          (TICK_HZ)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.res    (res)
	);

	// Once a word is taken the block is busy with it in the next cycle.
	`BTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)
	// A stopped tone never drives the buzzer.
	`BTS_ASSERT_SAME(a_quiet_when_idle, clk, arst_n, res_valid && !res.busy_res, !res.pwm_out)

endmodule

@@ sv/bts_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_div
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ---------------------------------------------------------------------------
module bts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bts_pkg::LONG_W-1:0]    dividend,
	input  logic [bts_pkg::HZ_W-1:0]      divisor,
	output logic [bts_pkg::LONG_W-1:0]    quotient,
	output logic                          done
);

	logic                          busy_q;
	logic                          done_q;
	logic [bts_pkg::STEP_W-1:0]    step_q;
	logic [bts_pkg::LONG_W-1:0]    quo_q;
	logic [bts_pkg::HZ_W-1:0]      rem_q;
	logic [bts_pkg::HZ_W-1:0]      dvs_q;
	logic [bts_pkg::HZ_W:0]        trial;
	logic [bts_pkg::HZ_W:0]        diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[bts_pkg::LONG_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= bts_pkg::STEP_W'(bts_pkg::LONG_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q as the quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bts_pkg::LONG_W-2:0], ge};
			rem_q <= ge ? diff[bts_pkg::HZ_W-1:0] : trial[bts_pkg::HZ_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ sv/bts_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_dp
// Tone datapath: item register, period and duration counters, click toggling,
// period top arithmetic and the result register.
// ---------------------------------------------------------------------------
module bts_dp #(
	parameter int PERIODS_PER_UNIT = 300,
	parameter int TICK_HZ          = 800000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bts_pkg::cmd_t    item,
	input  bts_pkg::dp_cmd_t ctl,
	output bts_pkg::dp_sts_t sts,
	output bts_pkg::res_t    res
);

	localparam logic [10:0]                 PPU_C  = 11'(PERIODS_PER_UNIT);
	localparam logic [bts_pkg::LONG_W-1:0]  TICK_C = bts_pkg::LONG_W'(TICK_HZ);

	bts_pkg::cmd_t                 item_q;
	logic [bts_pkg::LONG_W-1:0]    dl_calc_q;
	logic [bts_pkg::CNT_W-1:0]     top_new_q;
	bts_pkg::res_t                 res_q;

	logic [bts_pkg::CNT_W-1:0]     count_q;
	logic [bts_pkg::CNT_W-1:0]     top_q;
	logic [bts_pkg::CNT_W-1:0]     half_q;
	logic [bts_pkg::CNT_W-1:0]     duty_q;
	logic                          running_q;
	logic [bts_pkg::MODE_W-1:0]    mode_q;
	logic [bts_pkg::LONG_W-1:0]    elapsed_q;
	logic [bts_pkg::LONG_W-1:0]    clickp_q;
	logic [bts_pkg::LONG_W-1:0]    click_lim_q;
	logic [bts_pkg::LONG_W-1:0]    dur_lim_q;
	logic                          click_en_q;

	logic                          div_start;
	logic [bts_pkg::LONG_W-1:0]    div_dividend;
	logic [bts_pkg::HZ_W-1:0]      div_divisor;
	logic [bts_pkg::LONG_W-1:0]    quotient;
	logic                          div_done;
	logic [bts_pkg::CNT_W-1:0]     top_calc;
	logic [26:0]                   dl_prod;

	logic [bts_pkg::CNT_W-1:0]     count_n;
	logic [bts_pkg::CNT_W-1:0]     duty_n;
	logic                          running_n;
	logic [bts_pkg::LONG_W-1:0]    elapsed_n;
	logic [bts_pkg::LONG_W-1:0]    clickp_n;

	assign dl_prod = 27'(item_q.duration) * 27'(PPU_C);

	assign div_start    = ctl.div_hz | ctl.div_click;
	assign div_dividend = ctl.div_hz ? TICK_C : dl_calc_q;
	assign div_divisor  = ctl.div_hz ? item_q.tone_hz
	                                 : {{(bts_pkg::HZ_W - bts_pkg::CLK_W - 1){1'b0}},
	                                    item_q.click_count, 1'b0};

	bts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// A zero tone and an over-long period both give the largest top.
	always_comb begin
		if (item_q.tone_hz == '0) begin
			top_calc = bts_pkg::TOP_MAX;
		end else if (quotient == '0) begin
			top_calc = '0;
		end else if (quotient > bts_pkg::LONG_W'(32'h10000)) begin
			top_calc = bts_pkg::TOP_MAX;
		end else begin
			top_calc = bts_pkg::CNT_W'(quotient - 1'b1);
		end
	end

	// Next state for one timer tick.
	always_comb begin
		logic [bts_pkg::LONG_W-1:0] cp_t;
		count_n   = count_q;
		duty_n    = duty_q;
		running_n = running_q;
		elapsed_n = elapsed_q;
		clickp_n  = clickp_q;
		cp_t      = clickp_q;
		if (running_q) begin
			if (count_q >= top_q) begin
				count_n = '0;
				if (mode_q == bts_pkg::MODE_CLICK && click_en_q) begin
					if (clickp_q > click_lim_q) begin
						duty_n = (duty_q == '0) ? half_q : '0;
						cp_t   = '0;
					end
					clickp_n = cp_t + 1'b1;
				end
				if (elapsed_q > dur_lim_q) begin
					duty_n    = '0;
					running_n = 1'b0;
				end else begin
					elapsed_n = elapsed_q + 1'b1;
				end
			end else begin
				count_n = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= item;
		end
		if (ctl.div_hz) begin
			dl_calc_q <= dl_prod[bts_pkg::LONG_W-1:0];
		end
		if (ctl.div_click) begin
			top_new_q <= top_calc;
		end
		if (ctl.res_load) begin
			res_q.pwm_out  <= running_q && (count_q < duty_q);
			res_q.busy_res <= running_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			top_q       <= bts_pkg::TOP_RESET;
			half_q      <= '0;
			duty_q      <= '0;
			running_q   <= 1'b0;
			mode_q      <= bts_pkg::MODE_STOP;
			elapsed_q   <= '0;
			clickp_q    <= '0;
			click_lim_q <= '0;
			dur_lim_q   <= '0;
			click_en_q  <= 1'b0;
		end else if (ctl.load) begin
			mode_q      <= item_q.play_mode;
			dur_lim_q   <= dl_calc_q;
			elapsed_q   <= '0;
			clickp_q    <= '0;
			count_q     <= '0;
			click_en_q  <= item_q.click_count != '0;
			click_lim_q <= (item_q.click_count != '0) ? quotient : '0;
			if (item_q.play_mode == bts_pkg::MODE_STOP) begin
				duty_q    <= '0;
				running_q <= 1'b0;
			end else begin
				top_q     <= top_new_q;
				half_q    <= top_new_q >> 1;
				duty_q    <= top_new_q >> 1;
				running_q <= 1'b1;
			end
		end else if (ctl.tick) begin
			count_q   <= count_n;
			duty_q    <= duty_n;
			running_q <= running_n;
			elapsed_q <= elapsed_n;
			clickp_q  <= clickp_n;
		end
	end

	assign sts.kind     = item_q.kind;
	assign sts.div_done = div_done;
	assign res          = res_q;

endmodule

@@ sv/bts_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_ctrl
// Sequencer for the buzzer datapath: takes one word at a time, runs the tick
// update or the two divisions of a start, and hands the result word out.
// ---------------------------------------------------------------------------
module bts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	output logic             res_valid,
	input  logic             res_stall,
	input  bts_pkg::dp_sts_t sts,
	output bts_pkg::dp_cmd_t ctl
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DIV_HZ = 3'd2;
	localparam logic [2:0] ST_DIV_CL = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;
	logic       res_valid_q;
	logic       out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_n = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					state_n     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.kind) begin
					ctl.div_hz = 1'b1;
					state_n    = ST_DIV_HZ;
				end else begin
					ctl.tick = 1'b1;
					state_n  = ST_RESP;
				end
			end
			ST_DIV_HZ: begin
				// The period top is saved as the second division starts.
				if (sts.div_done) begin
					ctl.div_click = 1'b1;
					state_n       = ST_DIV_CL;
				end
			end
			ST_DIV_CL: begin
				if (sts.div_done) begin
					ctl.load = 1'b1;
					state_n  = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					ctl.res_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = state_q != ST_IDLE;
	assign res_valid = res_valid_q;

endmodule
